// ----- rtl/keyword_substitution_cipher_unit_macros.svh -----
// Assertion helpers shared by the cipher block.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KSCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KSCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kscu_pkg.sv -----
`timescale 1ns / 1ps
package kscu_pkg;

    localparam int ALPHA_N = 26;
    localparam int IDX_W   = 5;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam int APB_AW = 2;
    localparam logic [APB_AW-1:0] ADDR_DECRYPT_MODE = 2'd0;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_KEY   = 2'd1,
        OP_FILL  = 2'd2,
        OP_TEXT  = 2'd3
    } opcode_t;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic clear;
        logic key;
        logic fill_start;
        logic fill_step;
        logic text;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic fill_last;
        logic slot_free;
    } dp_stat_t;

endpackage

// ----- rtl/kscu_ifs.sv -----
`timescale 1ns / 1ps
interface kscu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_in;

    modport source (output valid, output opcode, output char_in, input ready);
    modport sink (input valid, input opcode, input char_in, output ready);
endinterface

interface kscu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       was_mapped;

    modport source (output valid, output char_out, output was_mapped, input ready);
    modport sink (input valid, input char_out, input was_mapped, output ready);
endinterface

// ----- rtl/kscu_ctrl.sv -----
`timescale 1ns / 1ps
module kscu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_opcode,
    input  kscu_pkg::dp_stat_t stat,
    output logic               in_ready,
    output kscu_pkg::dp_cmd_t  cmd
);
    import kscu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FILL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && stat.slot_free;
        accept     = in_valid && in_ready;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode_t'(in_opcode))
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_KEY:   cmd.key   = !stat.complete;
                        OP_FILL:
                        begin
                            if (!stat.complete)
                            begin
                                cmd.fill_start = 1'b1;
                                state_next     = ST_FILL;
                            end
                        end
                        OP_TEXT:  cmd.text  = 1'b1;
                        default:  cmd       = '0;
                    endcase
                end
            end
            ST_FILL:
            begin
                // one letter, z down to a, per cycle
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/kscu_datapath.sv -----
`timescale 1ns / 1ps
module kscu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  kscu_pkg::dp_cmd_t  cmd,
    output kscu_pkg::dp_stat_t stat,
    input  logic               decrypt_mode,
    input  logic [7:0]         in_char,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [7:0]         out_char,
    output logic               out_mapped
);
    import kscu_pkg::*;

    // forward: slot -> letter, inverse: letter -> slot; both written on append
    idx_t fwd_reg [ALPHA_N];
    idx_t inv_reg [ALPHA_N];

    logic [ALPHA_N-1:0] used_reg;
    logic [ALPHA_N-1:0] used_next;
    idx_t               fill_count_reg;
    idx_t               fill_count_next;
    idx_t               fill_k_reg;
    idx_t               fill_k_next;
    logic               complete_reg;
    logic               complete_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_char_reg;
    logic [7:0]         out_char_next;
    logic               out_mapped_reg;
    logic               out_mapped_next;

    logic is_upper;
    logic is_lower;
    logic is_letter;
    idx_t char_idx;
    idx_t app_idx;
    logic app_en;
    logic do_app;
    idx_t lookup;
    logic mapped;

    always_comb
    begin
        is_upper  = (in_char >= CH_UPPER_A) && (in_char <= CH_UPPER_Z);
        is_lower  = (in_char >= CH_LOWER_A) && (in_char <= CH_LOWER_Z);
        is_letter = is_upper || is_lower;
        // low five bits of a letter run 1..26 in either case
        char_idx  = in_char[IDX_W-1:0] - idx_t'(1);

        app_idx = cmd.fill_step ? fill_k_reg : char_idx;
        app_en  = cmd.fill_step || (cmd.key && is_letter);
        do_app  = app_en && !used_reg[app_idx] && (fill_count_reg < idx_t'(ALPHA_N));

        used_next       = used_reg;
        fill_count_next = fill_count_reg;
        complete_next   = complete_reg;
        fill_k_next     = fill_k_reg;

        if (cmd.clear)
        begin
            used_next       = '0;
            fill_count_next = '0;
            complete_next   = 1'b0;
        end
        if (do_app)
        begin
            used_next[app_idx] = 1'b1;
            fill_count_next    = fill_count_reg + idx_t'(1);
        end
        if (cmd.fill_start)
        begin
            fill_k_next = idx_t'(ALPHA_N - 1);
        end
        else if (cmd.fill_step)
        begin
            fill_k_next = fill_k_reg - idx_t'(1);
            if (fill_k_reg == '0)
            begin
                complete_next = 1'b1;
            end
        end

        lookup          = decrypt_mode ? inv_reg[char_idx] : fwd_reg[char_idx];
        mapped          = complete_reg && is_letter;
        out_char_next   = mapped ? {in_char[7:IDX_W], lookup + idx_t'(1)} : in_char;
        out_mapped_next = mapped;

        out_valid_next = out_valid_reg;
        if (cmd.text)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        stat.complete  = complete_reg;
        stat.fill_last = (fill_k_reg == '0);
        stat.slot_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            fill_count_reg <= '0;
            fill_k_reg     <= '0;
            complete_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            fill_count_reg <= fill_count_next;
            fill_k_reg     <= fill_k_next;
            complete_reg   <= complete_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_app)
        begin
            fwd_reg[fill_count_reg] <= app_idx;
            inv_reg[app_idx]        <= fill_count_reg;
        end
        if (cmd.text)
        begin
            out_char_reg   <= out_char_next;
            out_mapped_reg <= out_mapped_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_mapped = out_mapped_reg;

endmodule

// ----- rtl/keyword_substitution_cipher_unit.sv -----
`timescale 1ns / 1ps
// Keyword substitution cipher.
// Input channel in_ch carries an opcode and a byte: clear table, keyword byte,
// end of keyword, text byte. Only a text byte gives a word on out_ch
// (char_out, was_mapped); the other opcodes give none.
// A text byte shows on out_ch the cycle after it is taken; text bytes are
// taken one per cycle while out_ch keeps up.
// End of keyword on an incomplete table fills the unused letters z to a, one
// per cycle; in_ch is not ready until the fill is done.
// out_ch is a single output register: when the receiver stalls, the word
// holds and in_ch is not ready until it is taken.
// Reset empties the table (text passes through unmapped until a keyword is
// ended) and sets decrypt_mode to 0. decrypt_mode sits at APB address 0;
// write it only while the block is idle.
`include "keyword_substitution_cipher_unit_macros.svh"

module keyword_substitution_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    kscu_in_if.sink                       in_ch,
    kscu_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kscu_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import kscu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     decrypt_mode_reg;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DECRYPT_MODE);
    assign prdata = (paddr == ADDR_DECRYPT_MODE) ? {31'd0, decrypt_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            decrypt_mode_reg <= pwdata[0];
        end
    end

    kscu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .stat      (stat),
        .in_ready  (in_ch.ready),
        .cmd       (cmd)
    );

    kscu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .decrypt_mode (decrypt_mode_reg),
        .in_char      (in_ch.char_in),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_char     (out_ch.char_out),
        .out_mapped   (out_ch.was_mapped)
    );

    `KSCU_ASSERT_NEXT(a_fill_blocks_input, clk, rst_n,
        in_ch.valid && in_ch.ready && (in_ch.opcode == OP_FILL) && !stat.complete,
        !in_ch.ready, "input taken while table fill in progress")

    `KSCU_ASSERT_NEXT(a_text_gives_word, clk, rst_n,
        in_ch.valid && in_ch.ready && (in_ch.opcode == OP_TEXT),
        out_ch.valid, "text byte did not produce an output word")

    `KSCU_ASSERT_NOW(a_mapped_is_letter, clk, rst_n,
        out_ch.valid && out_ch.was_mapped,
        ((out_ch.char_out >= CH_LOWER_A) && (out_ch.char_out <= CH_LOWER_Z)) ||
        ((out_ch.char_out >= CH_UPPER_A) && (out_ch.char_out <= CH_UPPER_Z)),
        "mapped output is not a letter")

endmodule
